// File: src/ahed_pkg.sv
`timescale 1ns / 1ps

package ahed_pkg;

    // Fixed-point format of the tracked values
    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_W    = 16;
    localparam int VAL_W       = SAMPLE_W + FRAC_BITS;
    localparam int DC_W        = VAL_W + 1;
    localparam int ENV_W       = VAL_W + 2;
    localparam int DIFF_W      = ENV_W + 1;

    // Rate register and averaging shift
    localparam int RATE_W      = 18;
    localparam int SHIFT_W     = 4;
    localparam int RATE_DIV    = 80;
    localparam int SHIFT_MIN   = 1;
    localparam int SHIFT_MAX   = 11;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    // Hysteresis floor, scaled into fixed point
    localparam int FLOOR_LEVEL = 150;
    localparam logic signed [DIFF_W-1:0] FLOOR_VAL = DIFF_W'(FLOOR_LEVEL << FRAC_BITS);

    // Tracker state carried from one item to the next
    typedef struct packed {
        logic                    level;
        logic                    first;
        logic signed [DC_W-1:0]  dc;
        logic signed [ENV_W-1:0] env;
    } ahed_state_t;

    // Largest s in 1..11 with 2^s <= rate/80, at least 1: rate >= 80 * 2^s
    function automatic logic [SHIFT_W-1:0] avg_shift(input logic [RATE_W-1:0] rate);
        logic [SHIFT_W-1:0] s;
        s = SHIFT_W'(SHIFT_MIN);
        for (int k = SHIFT_MIN + 1; k <= SHIFT_MAX; k++) begin
            if ({1'b0, rate} >= (RATE_W + 1)'(RATE_DIV << k)) begin
                s = SHIFT_W'(k);
            end
        end
        return s;
    endfunction

endpackage

// File: src/ahed_update.sv
`timescale 1ns / 1ps

module ahed_update (
    input  logic signed [ahed_pkg::SAMPLE_W-1:0] sample,
    input  logic        [ahed_pkg::SHIFT_W-1:0]  shift,
    input  ahed_pkg::ahed_state_t                state_cur,
    output ahed_pkg::ahed_state_t                state_nxt,
    output logic                                 edge_res
);

    logic signed [ahed_pkg::VAL_W-1:0]  val;
    logic signed [ahed_pkg::DC_W-1:0]   dc_base;
    logic signed [ahed_pkg::DIFF_W-1:0] dc_diff;
    logic signed [ahed_pkg::DIFF_W-1:0] dc_step;
    logic signed [ahed_pkg::DIFF_W-1:0] dc_sum;
    logic signed [ahed_pkg::DC_W-1:0]   dc_new;
    logic signed [ahed_pkg::DIFF_W-1:0] dev;
    logic signed [ahed_pkg::DIFF_W-1:0] mag;
    logic signed [ahed_pkg::DIFF_W-1:0] env_diff;
    logic signed [ahed_pkg::DIFF_W-1:0] env_step;
    logic signed [ahed_pkg::DIFF_W-1:0] env_sum;
    logic signed [ahed_pkg::ENV_W-1:0]  env_new;
    logic signed [ahed_pkg::DIFF_W-1:0] hyst_raw;
    logic signed [ahed_pkg::DIFF_W-1:0] hyst;
    logic                               toggle;

    // Scale the sample into fixed point
    assign val = {sample, {ahed_pkg::FRAC_BITS{1'b0}}};

    // Seed the DC tracker on the first item, then take one averaging step
    assign dc_base = state_cur.first ? ahed_pkg::DC_W'(val) : state_cur.dc;
    assign dc_diff = ahed_pkg::DIFF_W'(val) - ahed_pkg::DIFF_W'(dc_base);
    assign dc_step = dc_diff >>> shift;
    assign dc_sum  = ahed_pkg::DIFF_W'(dc_base) + dc_step;
    assign dc_new  = dc_sum[ahed_pkg::DC_W-1:0];

    // Deviation from DC and its magnitude
    assign dev = ahed_pkg::DIFF_W'(val) - ahed_pkg::DIFF_W'(dc_new);
    assign mag = dev[ahed_pkg::DIFF_W-1] ? -dev : dev;

    // Envelope averages with one more bit of shift
    assign env_diff = mag - ahed_pkg::DIFF_W'(state_cur.env);
    assign env_step = env_diff >>> (shift + ahed_pkg::SHIFT_W'(1));
    assign env_sum  = ahed_pkg::DIFF_W'(state_cur.env) + env_step;
    assign env_new  = env_sum[ahed_pkg::ENV_W-1:0];

    // Hysteresis is a quarter of the envelope, held above the floor
    assign hyst_raw = ahed_pkg::DIFF_W'(env_new) >>> 2;
    assign hyst     = (hyst_raw < ahed_pkg::FLOOR_VAL) ? ahed_pkg::FLOOR_VAL : hyst_raw;

    // Toggle when the deviation crosses the opposite threshold
    assign toggle = state_cur.level ? (dev < -hyst) : (dev > hyst);

    always_comb begin
        state_nxt.level = state_cur.level ^ toggle;
        state_nxt.first = 1'b0;
        state_nxt.dc    = dc_new;
        state_nxt.env   = env_new;
        edge_res        = toggle;
    end

endmodule

// File: src/adaptive_hysteresis_edge_detector.sv
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Content
// input     s_valid s_ready s_sample       in         signed 16-bit audio sample
// result    m_valid m_ready m_edge_res     out        toggle flag and level after
//           m_level                                    the sample
// config    cfg_wr_en cfg_wr_data          in         sample rate in Hz, 18 bits
//
// One item is taken per cycle unless the result side stalls; an accepted item
// waits in the input register and moves into the result register once that is
// free. The tracker update is a single pass of adds, shifts and compares. A
// stalled result holds the result register and then the input register; the
// input side is ready again as soon as the result register can move.
// Synchronous active-low reset clears state and loads the 44100 Hz shift.

module adaptive_hysteresis_edge_detector (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ahed_pkg::RATE_W-1:0]          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ahed_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_edge_res,
    output logic                                 m_level
);

    logic                                 in_valid_reg;
    logic signed [ahed_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic [ahed_pkg::SHIFT_W-1:0]         shift_reg;
    ahed_pkg::ahed_state_t                state_reg;
    ahed_pkg::ahed_state_t                state_next;
    logic                                 edge_next;
    logic                                 out_valid_reg;
    logic                                 out_edge_reg;
    logic                                 out_level_reg;
    logic                                 advance;

    // Move the held item into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ahed_update u_update (
        .sample    (in_sample_reg),
        .shift     (shift_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .edge_res  (edge_next)
    );

    // Derive the averaging shift whenever the rate is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= ahed_pkg::avg_shift(ahed_pkg::RATE_RESET);
        end else if (cfg_wr_en) begin
            shift_reg <= ahed_pkg::avg_shift(cfg_wr_data);
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sample_reg <= s_sample;
        end
    end

    // Tracker state advances with each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.level <= 1'b0;
            state_reg.first <= 1'b1;
            state_reg.dc    <= '0;
            state_reg.env   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_edge_reg  <= edge_next;
            out_level_reg <= state_next.level;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_edge_res = out_edge_reg;
    assign m_level    = out_level_reg;

    // Checks on the tracker
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> !state_reg.first)
        else $error("first-item flag still set after an item");

    a_level_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_level == state_reg.level))
        else $error("result level differs from tracked level");

    a_edge_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_edge_res == (m_level != $past(state_reg.level))))
        else $error("edge flag does not match a level change");

    a_env_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.env[ahed_pkg::ENV_W-1])
        else $error("envelope went negative");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift_reg >= ahed_pkg::SHIFT_W'(ahed_pkg::SHIFT_MIN)) &&
        (shift_reg <= ahed_pkg::SHIFT_W'(ahed_pkg::SHIFT_MAX)))
        else $error("averaging shift out of range");

endmodule
